// ----- sv/bir_pkg.sv -----
package bir_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 16;

    localparam int POS_W      = 8;
    localparam int CH_W       = 8;
    localparam int STEP_W     = 24;
    localparam int SIZE_REG_W = 9;
    localparam int IDX_W      = 2;
    localparam int WGT_W      = 8;
    localparam int WGT_ONE    = 1 << WGT_W;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int XSZ_W   = $clog2(MAX_WIDTH + 1);
    localparam int YSZ_W   = $clog2(MAX_HEIGHT + 1);
    localparam int BANK_AW = (COL_W - 1) + (ROW_W - 1);
    localparam int PROD_W  = POS_W + STEP_W;
    localparam int IP_W    = PROD_W - FRAC_BITS;

    localparam logic [SIZE_REG_W-1:0] WIDTH_RESET  = SIZE_REG_W'(256);
    localparam logic [SIZE_REG_W-1:0] HEIGHT_RESET = SIZE_REG_W'(256);
    localparam logic [STEP_W-1:0]     STEP_RESET   = STEP_W'(65536);

    typedef enum logic [IDX_W-1:0] {
        REG_SOURCE_WIDTH    = 2'd0,
        REG_SOURCE_HEIGHT   = 2'd1,
        REG_HORIZONTAL_STEP = 2'd2,
        REG_VERTICAL_STEP   = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_SAMPLE = 1'b1
    } action_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t ul;
        rgb_t ur;
        rgb_t dl;
        rgb_t dr;
    } quad_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [COL_W-1:0] col_lo;
        logic [COL_W-1:0] col_hi;
        logic [ROW_W-1:0] row_lo;
        logic [ROW_W-1:0] row_hi;
        logic [COL_W-1:0] wr_col;
        logic [ROW_W-1:0] wr_row;
        rgb_t             wr_data;
    } store_req_t;

    typedef struct packed {
        logic s4;
        logic s5;
    } blend_en_t;

endpackage

// ----- sv/bir_store.sv -----
module bir_store
    import bir_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output quad_t      quad
);

    localparam int BANK_DEPTH = 1 << BANK_AW;

    rgb_t bank_q_reg [4];
    logic lo_x0_reg;
    logic hi_x0_reg;
    logic lo_y0_reg;
    logic hi_y0_reg;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BX = 1'(b % 2);
        localparam logic BY = 1'(b / 2);

        rgb_t               mem [BANK_DEPTH];
        logic [COL_W-1:0]   rd_col;
        logic [ROW_W-1:0]   rd_row;
        logic [BANK_AW-1:0] rd_addr;
        logic [BANK_AW-1:0] wr_addr;
        logic               wr_hit;

        always_comb
        begin
            rd_col  = (req.col_lo[0] == BX) ? req.col_lo : req.col_hi;
            rd_row  = (req.row_lo[0] == BY) ? req.row_lo : req.row_hi;
            rd_addr = {rd_row[ROW_W-1:1], rd_col[COL_W-1:1]};
            wr_addr = {req.wr_row[ROW_W-1:1], req.wr_col[COL_W-1:1]};
            wr_hit  = req.wr_en && (req.wr_col[0] == BX) && (req.wr_row[0] == BY);
        end

        always_ff @(posedge clk)
        begin
            if (wr_hit)
            begin
                mem[wr_addr] <= req.wr_data;
            end
            if (req.rd_en)
            begin
                bank_q_reg[b] <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            lo_x0_reg <= req.col_lo[0];
            hi_x0_reg <= req.col_hi[0];
            lo_y0_reg <= req.row_lo[0];
            hi_y0_reg <= req.row_hi[0];
        end
    end

    always_comb
    begin
        quad.ul = bank_q_reg[{lo_y0_reg, lo_x0_reg}];
        quad.ur = bank_q_reg[{lo_y0_reg, hi_x0_reg}];
        quad.dl = bank_q_reg[{hi_y0_reg, lo_x0_reg}];
        quad.dr = bank_q_reg[{hi_y0_reg, hi_x0_reg}];
    end

endmodule

// ----- sv/bir_blend.sv -----
module bir_blend
    import bir_pkg::*;
(
    input  logic             clk,
    input  blend_en_t        en,
    input  logic [CH_W-1:0]  ul,
    input  logic [CH_W-1:0]  ur,
    input  logic [CH_W-1:0]  dl,
    input  logic [CH_W-1:0]  dr,
    input  logic [WGT_W-1:0] fx,
    input  logic [WGT_W-1:0] fy,
    output logic [CH_W-1:0]  value
);

    localparam int H_W = CH_W + WGT_W;
    localparam int V_W = H_W + WGT_W;

    logic [WGT_W:0]   fx_inv;
    logic [WGT_W:0]   fy_inv;
    logic [H_W:0]     top_sum;
    logic [H_W:0]     bot_sum;
    logic [V_W:0]     v_sum;
    logic [H_W-1:0]   top_reg;
    logic [H_W-1:0]   bot_reg;
    logic [WGT_W-1:0] fy_reg;
    logic [CH_W-1:0]  value_reg;

    always_comb
    begin
        fx_inv  = (WGT_W + 1)'(WGT_ONE) - {1'b0, fx};
        top_sum = (H_W + 1)'(ul) * (H_W + 1)'(fx_inv) + (H_W + 1)'(ur) * (H_W + 1)'(fx);
        bot_sum = (H_W + 1)'(dl) * (H_W + 1)'(fx_inv) + (H_W + 1)'(dr) * (H_W + 1)'(fx);
        fy_inv  = (WGT_W + 1)'(WGT_ONE) - {1'b0, fy_reg};
        v_sum   = (V_W + 1)'(top_reg) * (V_W + 1)'(fy_inv)
                + (V_W + 1)'(bot_reg) * (V_W + 1)'(fy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            top_reg <= top_sum[H_W-1:0];
            bot_reg <= bot_sum[H_W-1:0];
            fy_reg  <= fy;
        end
        if (en.s5)
        begin
            value_reg <= v_sum[2*WGT_W +: CH_W];
        end
    end

    assign value = value_reg;

endmodule

// ----- sv/bilinear_image_resampler_unit.sv -----
// Bilinear resampler: load items write one source pixel, sample items return one
// blended pixel each, at a sustained rate of one item per clock while the output
// is not stalled. An accepted sample passes through registers s1 to s4 and the
// output register; a load produces no result transfer. The rate is set by the
// pixel store, which is split into four banks by column and row parity so that
// the four neighbors of a sample are read in the same cycle. A load is visible
// to any sample accepted after it. The store is not cleared after reset: a sample
// that touches a pixel never loaded returns an arbitrary color. Configuration
// must only be written while the pipeline is empty.
module bilinear_image_resampler_unit
    import bir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [STEP_W-1:0]     cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic [CH_W-1:0]       in_red,
    input  logic [CH_W-1:0]       in_green,
    input  logic [CH_W-1:0]       in_blue,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [POS_W-1:0]      out_x,
    output logic [POS_W-1:0]      out_y,
    output logic [CH_W-1:0]       out_red,
    output logic [CH_W-1:0]       out_green,
    output logic [CH_W-1:0]       out_blue
);

    localparam int XCMP_W = (SIZE_REG_W > XSZ_W) ? SIZE_REG_W : XSZ_W;
    localparam int YCMP_W = (SIZE_REG_W > YSZ_W) ? SIZE_REG_W : YSZ_W;
    localparam int IXC_W  = (IP_W > COL_W) ? IP_W : COL_W;
    localparam int IYC_W  = (IP_W > ROW_W) ? IP_W : ROW_W;
    localparam int PXC_W  = (POS_W > XSZ_W) ? POS_W : XSZ_W;
    localparam int PYC_W  = (POS_W > YSZ_W) ? POS_W : YSZ_W;

    logic [SIZE_REG_W-1:0] cfg_width_reg;
    logic [SIZE_REG_W-1:0] cfg_height_reg;
    logic [STEP_W-1:0]     cfg_hstep_reg;
    logic [STEP_W-1:0]     cfg_vstep_reg;

    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;

    logic              s1_valid_reg;
    action_t           s1_action_reg;
    logic [POS_W-1:0]  s1_x_reg;
    logic [POS_W-1:0]  s1_y_reg;
    rgb_t              s1_rgb_reg;
    logic [PROD_W-1:0] s1_prod_x_reg;
    logic [PROD_W-1:0] s1_prod_y_reg;

    logic [XSZ_W-1:0] width_eff;
    logic [YSZ_W-1:0] height_eff;
    logic [COL_W-1:0] last_x;
    logic [ROW_W-1:0] last_y;
    logic [IP_W-1:0]  ip_x;
    logic [IP_W-1:0]  ip_y;
    logic [COL_W-1:0] lo_x_next;
    logic [COL_W-1:0] hi_x_next;
    logic [ROW_W-1:0] lo_y_next;
    logic [ROW_W-1:0] hi_y_next;

    logic             s2_valid_reg;
    action_t          s2_action_reg;
    logic [POS_W-1:0] s2_x_reg;
    logic [POS_W-1:0] s2_y_reg;
    rgb_t             s2_rgb_reg;
    logic [COL_W-1:0] s2_lo_x_reg;
    logic [COL_W-1:0] s2_hi_x_reg;
    logic [ROW_W-1:0] s2_lo_y_reg;
    logic [ROW_W-1:0] s2_hi_y_reg;
    logic [WGT_W-1:0] s2_fx_reg;
    logic [WGT_W-1:0] s2_fy_reg;
    logic             load_in_store;

    store_req_t store_req;
    quad_t      quad;

    logic             s3_valid_reg;
    logic [POS_W-1:0] s3_x_reg;
    logic [POS_W-1:0] s3_y_reg;
    logic [WGT_W-1:0] s3_fx_reg;
    logic [WGT_W-1:0] s3_fy_reg;

    logic             s4_valid_reg;
    logic [POS_W-1:0] s4_x_reg;
    logic [POS_W-1:0] s4_y_reg;

    logic             out_valid_reg;
    logic [POS_W-1:0] out_x_reg;
    logic [POS_W-1:0] out_y_reg;

    blend_en_t blend_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= WIDTH_RESET;
            cfg_height_reg <= HEIGHT_RESET;
            cfg_hstep_reg  <= STEP_RESET;
            cfg_vstep_reg  <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SOURCE_WIDTH:    cfg_width_reg  <= cfg_data[SIZE_REG_W-1:0];
                REG_SOURCE_HEIGHT:   cfg_height_reg <= cfg_data[SIZE_REG_W-1:0];
                REG_HORIZONTAL_STEP: cfg_hstep_reg  <= cfg_data;
                REG_VERTICAL_STEP:   cfg_vstep_reg  <= cfg_data;
                default:             cfg_width_reg  <= cfg_width_reg;
            endcase
        end
    end

    // A stage moves forward when it is empty or the stage after it moves.
    assign en5      = !out_valid_reg || !out_stall;
    assign en4      = !s4_valid_reg || en5;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg && (s2_action_reg == ACT_SAMPLE);
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_action_reg <= action_t'(action);
            s1_x_reg      <= pos_x;
            s1_y_reg      <= pos_y;
            s1_rgb_reg    <= '{red: in_red, green: in_green, blue: in_blue};
            s1_prod_x_reg <= PROD_W'(pos_x) * PROD_W'(cfg_hstep_reg);
            s1_prod_y_reg <= PROD_W'(pos_y) * PROD_W'(cfg_vstep_reg);
        end
    end

    always_comb
    begin
        if (cfg_width_reg == '0)
        begin
            width_eff = XSZ_W'(1);
        end
        else if (XCMP_W'(cfg_width_reg) > XCMP_W'(MAX_WIDTH))
        begin
            width_eff = XSZ_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = XSZ_W'(cfg_width_reg);
        end

        if (cfg_height_reg == '0)
        begin
            height_eff = YSZ_W'(1);
        end
        else if (YCMP_W'(cfg_height_reg) > YCMP_W'(MAX_HEIGHT))
        begin
            height_eff = YSZ_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = YSZ_W'(cfg_height_reg);
        end

        last_x = COL_W'(width_eff - XSZ_W'(1));
        last_y = ROW_W'(height_eff - YSZ_W'(1));
        ip_x   = s1_prod_x_reg[PROD_W-1:FRAC_BITS];
        ip_y   = s1_prod_y_reg[PROD_W-1:FRAC_BITS];

        lo_x_next = (IXC_W'(ip_x) > IXC_W'(last_x)) ? last_x : COL_W'(ip_x);
        lo_y_next = (IYC_W'(ip_y) > IYC_W'(last_y)) ? last_y : ROW_W'(ip_y);
        hi_x_next = (lo_x_next == last_x) ? last_x : lo_x_next + COL_W'(1);
        hi_y_next = (lo_y_next == last_y) ? last_y : lo_y_next + ROW_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_action_reg <= s1_action_reg;
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_rgb_reg    <= s1_rgb_reg;
            s2_lo_x_reg   <= lo_x_next;
            s2_hi_x_reg   <= hi_x_next;
            s2_lo_y_reg   <= lo_y_next;
            s2_hi_y_reg   <= hi_y_next;
            s2_fx_reg     <= s1_prod_x_reg[FRAC_BITS-1 -: WGT_W];
            s2_fy_reg     <= s1_prod_y_reg[FRAC_BITS-1 -: WGT_W];
        end
    end

    always_comb
    begin
        load_in_store = (PXC_W'(s2_x_reg) < PXC_W'(MAX_WIDTH))
                     && (PYC_W'(s2_y_reg) < PYC_W'(MAX_HEIGHT));

        store_req.rd_en   = en3 && s2_valid_reg && (s2_action_reg == ACT_SAMPLE);
        store_req.wr_en   = en3 && s2_valid_reg && (s2_action_reg == ACT_LOAD)
                         && load_in_store;
        store_req.col_lo  = s2_lo_x_reg;
        store_req.col_hi  = s2_hi_x_reg;
        store_req.row_lo  = s2_lo_y_reg;
        store_req.row_hi  = s2_hi_y_reg;
        store_req.wr_col  = COL_W'(s2_x_reg);
        store_req.wr_row  = ROW_W'(s2_y_reg);
        store_req.wr_data = s2_rgb_reg;
    end

    bir_store u_store (
        .clk  (clk),
        .req  (store_req),
        .quad (quad)
    );

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_x_reg  <= s2_x_reg;
            s3_y_reg  <= s2_y_reg;
            s3_fx_reg <= s2_fx_reg;
            s3_fy_reg <= s2_fy_reg;
        end
        if (en4)
        begin
            s4_x_reg <= s3_x_reg;
            s4_y_reg <= s3_y_reg;
        end
        if (en5)
        begin
            out_x_reg <= s4_x_reg;
            out_y_reg <= s4_y_reg;
        end
    end

    assign blend_en.s4 = en4;
    assign blend_en.s5 = en5;

    bir_blend u_blend_red (
        .clk   (clk),
        .en    (blend_en),
        .ul    (quad.ul.red),
        .ur    (quad.ur.red),
        .dl    (quad.dl.red),
        .dr    (quad.dr.red),
        .fx    (s3_fx_reg),
        .fy    (s3_fy_reg),
        .value (out_red)
    );

    bir_blend u_blend_green (
        .clk   (clk),
        .en    (blend_en),
        .ul    (quad.ul.green),
        .ur    (quad.ur.green),
        .dl    (quad.dl.green),
        .dr    (quad.dr.green),
        .fx    (s3_fx_reg),
        .fy    (s3_fy_reg),
        .value (out_green)
    );

    bir_blend u_blend_blue (
        .clk   (clk),
        .en    (blend_en),
        .ul    (quad.ul.blue),
        .ur    (quad.ur.blue),
        .dl    (quad.dl.blue),
        .dr    (quad.dr.blue),
        .fx    (s3_fx_reg),
        .fy    (s3_fy_reg),
        .value (out_blue)
    );

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

    // The input is held back only when every stage holds an item behind a stalled output.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
                      && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline has room");

    // The right and bottom neighbors are the same as or one past the left and top ones.
    a_neighbor_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_action_reg == ACT_SAMPLE)) |->
        ((s2_hi_x_reg == s2_lo_x_reg) || (s2_hi_x_reg == s2_lo_x_reg + COL_W'(1)))
        && ((s2_hi_y_reg == s2_lo_y_reg) || (s2_hi_y_reg == s2_lo_y_reg + ROW_W'(1))))
        else $error("neighbor coordinates out of order");

    // A single item reaches the store per cycle, so a read and a write never coincide.
    a_store_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(store_req.rd_en && store_req.wr_en))
        else $error("store read and write in the same cycle");

endmodule
